/* src/crc16fa_pkg.sv */
// Shared constants, types and the CRC-16/MODBUS byte fold for the frame appender.
// No dependencies; every other file of the block refers to it by scoped names.
`default_nettype none

package crc16fa_pkg;

  localparam int unsigned ByteW      = 8;
  localparam int unsigned CrcW       = 16;
  localparam int unsigned CountW     = 6;
  localparam int unsigned PayloadDef = 8;

  localparam logic [CrcW-1:0] CrcInit = 16'hFFFF;
  localparam logic [CrcW-1:0] CrcPoly = 16'hA001;

  // Per-transaction report from the CRC tracker to the output stage.
  typedef struct packed {
    logic            close;
    logic [CrcW-1:0] crc;
  } crc_event_t;

  // Fold one byte into the reflected CRC, least significant bit first.
  function automatic logic [CrcW-1:0] crc_fold_byte(input logic [CrcW-1:0] crc_in,
                                                     input logic [ByteW-1:0] b);
    logic [CrcW-1:0] c;
    c = crc_in ^ {{(CrcW-ByteW){1'b0}}, b};
    for (int k = 0; k < ByteW; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* src/crc16fa_if.sv */
// Handshake interfaces for the payload input and the transmit output channels.
// Depends on crc16fa_pkg for the byte width.
`default_nettype none

interface crc16fa_in_if;
  logic                            valid;
  logic                            ready;
  logic [crc16fa_pkg::ByteW-1:0]   data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface crc16fa_out_if;
  logic                            valid;
  logic                            ready;
  logic [crc16fa_pkg::ByteW-1:0]   out_byte;
  logic                            frame_end;

  modport source (output valid, output out_byte, output frame_end, input ready);
  modport sink   (input valid, input out_byte, input frame_end, output ready);
endinterface

`default_nettype wire

/* src/crc16_frame_appender.sv */
// Top level of the CRC-16/MODBUS frame appender: payload pass-through plus CRC tail.
// Depends on crc16fa_pkg, crc16fa_if, crc16fa_crc_track and crc16fa_out_stage.
//
//   Channel   Direction  Payload fields          Meaning
//   payload   in         data_byte[7:0]          one payload byte of the frame
//   tx        out        out_byte[7:0],          payload byte, then CRC low, then
//                        frame_end               CRC high with frame_end set
//
// The CRC fold of a payload byte is a shallow XOR network between the CRC
// register and the output register, so one transaction per cycle is accepted
// while the output side keeps taking bytes and no CRC bytes are queued.
// The last payload byte of a frame queues two CRC bytes; the input is held off
// until the CRC high byte is in the output register.
// Reset (rst, synchronous) empties the output register, clears the CRC tail,
// sets the CRC to 0xFFFF and the byte count to zero. There is no clearing pass.
// A stall on tx holds the output register and, through ready, stops the input.
`default_nettype none

module crc16_frame_appender #(
  parameter int unsigned PAYLOAD_BYTES = crc16fa_pkg::PayloadDef
) (
  input  wire logic     clk,
  input  wire logic     rst,
  crc16fa_in_if.sink    payload,
  crc16fa_out_if.source tx
);

  crc16fa_pkg::crc_event_t ev;
  logic                    accept_ok;
  logic                    take;

  // A payload transaction completes when the output stage has room for it.
  assign payload.ready = accept_ok;
  assign take          = payload.valid && accept_ok;

  // The tracker folds the incoming byte and tells whether it closes the frame.
  crc16fa_crc_track #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_crc_track (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .data_byte (payload.data_byte),
    .ev        (ev)
  );

  // The output stage registers the byte and appends the CRC after a frame.
  crc16fa_out_stage u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .data_byte (payload.data_byte),
    .ev        (ev),
    .tx_ready  (tx.ready),
    .tx_valid  (tx.valid),
    .out_byte  (tx.out_byte),
    .frame_end (tx.frame_end),
    .accept_ok (accept_ok)
  );

  // A byte that closes a frame shows up next cycle with the CRC queued behind it.
  a_close_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (take && ev.close) |=> (tx.valid && !tx.frame_end && !payload.ready))
    else $error("closing byte did not hold off the input");

  // A byte that does not close a frame appears unchanged in the next cycle.
  a_pass_through: assert property (@(posedge clk) disable iff (rst)
    (take && !ev.close) |=> (tx.valid && !tx.frame_end &&
                             tx.out_byte == $past(payload.data_byte)))
    else $error("payload byte not passed to the output register");

  // Reset leaves the output side empty.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !tx.valid)
    else $error("output valid after reset");

endmodule

`default_nettype wire

/* src/crc16fa_crc_track.sv */
// Running CRC and payload byte count of the current frame.
// Depends on crc16fa_pkg for the CRC fold and the event struct.
`default_nettype none

module crc16fa_crc_track #(
  parameter int unsigned PAYLOAD_BYTES = crc16fa_pkg::PayloadDef
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          take,
  input  wire logic [crc16fa_pkg::ByteW-1:0] data_byte,
  output crc16fa_pkg::crc_event_t            ev
);

  logic [crc16fa_pkg::CrcW-1:0]   crc_acc;
  logic [crc16fa_pkg::CountW-1:0] byte_count;
  logic [crc16fa_pkg::CountW-1:0] count_next;

  localparam logic [crc16fa_pkg::CountW-1:0] LastCount =
    crc16fa_pkg::CountW'(PAYLOAD_BYTES);

  always_comb begin
    count_next = byte_count + 1'b1;
    ev.crc     = crc16fa_pkg::crc_fold_byte(crc_acc, data_byte);
    ev.close   = (count_next >= LastCount) || (count_next == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_acc    <= crc16fa_pkg::CrcInit;
      byte_count <= '0;
    end else if (take) begin
      if (ev.close) begin
        crc_acc    <= crc16fa_pkg::CrcInit;
        byte_count <= '0;
      end else begin
        crc_acc    <= ev.crc;
        byte_count <= count_next;
      end
    end
  end

endmodule

`default_nettype wire

/* src/crc16fa_out_stage.sv */
// Output register with a two-entry tail that sends the CRC low and high bytes.
// Depends on crc16fa_pkg for widths and the event struct.
`default_nettype none

module crc16fa_out_stage (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          take,
  input  wire logic [crc16fa_pkg::ByteW-1:0] data_byte,
  input  wire crc16fa_pkg::crc_event_t       ev,
  input  wire logic                          tx_ready,
  output logic                               tx_valid,
  output logic [crc16fa_pkg::ByteW-1:0]      out_byte,
  output logic                               frame_end,
  output logic                               accept_ok
);

  typedef enum logic [1:0] {
    PEND_NONE,
    PEND_LOW,
    PEND_HIGH
  } pend_t;

  pend_t                        pend;
  logic [crc16fa_pkg::CrcW-1:0] crc_hold;

  // A new byte may enter when no CRC bytes are queued and the output slot frees.
  assign accept_ok = (pend == PEND_NONE) && (!tx_valid || tx_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      tx_valid <= 1'b0;
      pend     <= PEND_NONE;
    end else if (take) begin
      tx_valid  <= 1'b1;
      out_byte  <= data_byte;
      frame_end <= 1'b0;
      if (ev.close) begin
        crc_hold <= ev.crc;
        pend     <= PEND_LOW;
      end
    end else if (tx_valid && tx_ready) begin
      unique case (pend)
        PEND_NONE: begin
          tx_valid <= 1'b0;
        end
        PEND_LOW: begin
          out_byte  <= crc_hold[crc16fa_pkg::ByteW-1:0];
          frame_end <= 1'b0;
          pend      <= PEND_HIGH;
        end
        PEND_HIGH: begin
          out_byte  <= crc_hold[crc16fa_pkg::CrcW-1:crc16fa_pkg::ByteW];
          frame_end <= 1'b1;
          pend      <= PEND_NONE;
        end
        default: begin
          pend <= PEND_NONE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* dv/crc16_frame_appender_test.sv */
// Self-checking testbench for crc16_frame_appender: random payload bytes, idling on both sides.
// Needs crc16fa_pkg, the crc16fa_in_if/crc16fa_out_if interfaces and the appender RTL.

module crc16_frame_appender_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ByteW      = crc16fa_pkg::ByteW;
  localparam int unsigned CrcW       = crc16fa_pkg::CrcW;
  localparam int unsigned CountW     = crc16fa_pkg::CountW;
  localparam logic [CrcW-1:0] CrcInit = crc16fa_pkg::CrcInit;
  localparam logic [CrcW-1:0] CrcPoly = crc16fa_pkg::CrcPoly;

  // Payload length that the block is built with, shared by the predictor.
  localparam int unsigned FrameBytes = crc16fa_pkg::PayloadDef;
  // Cycles with no transaction on either channel before the run is declared hung.
  localparam int unsigned QuietLimit = 2000;
  // Length of the long receiver hold-off that fills the block up.
  localparam int unsigned HoldCycles = 60;
  // Cycles to keep watching for stray output once the last expected byte arrived.
  localparam int unsigned TailCycles = 10;

  // One byte on the transmit side as the predictor expects it.
  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             frame_end;
  } tx_beat_t;

  // Follows the CRC over the current frame and keeps the transmit bytes that are still due.
  class crc_tail_tracker;
    logic [CrcW-1:0]   running_crc;
    logic [CountW-1:0] bytes_in_frame;
    tx_beat_t          tx_due[$];
    int unsigned       mismatch_count;

    function new();
      running_crc    = CrcInit;
      bytes_in_frame = '0;
      mismatch_count = 0;
    endfunction

    // An accepted payload byte is echoed at once; the last byte of a frame
    // is followed by the CRC, low byte first, and the frame state starts over.
    function void take_payload(logic [ByteW-1:0] value);
      tx_beat_t          beat;
      logic [CountW-1:0] count_after;
      int                bit_idx;
      beat.out_byte = value;
      beat.frame_end = 1'b0;
      tx_due.push_back(beat);
      running_crc = running_crc ^ {{(CrcW-ByteW){1'b0}}, value};
      for (bit_idx = 0; bit_idx < ByteW; bit_idx++) begin
        if (running_crc[0]) begin
          running_crc = (running_crc >> 1) ^ CrcPoly;
        end else begin
          running_crc = running_crc >> 1;
        end
      end
      count_after = bytes_in_frame + 1'b1;
      if (count_after >= FrameBytes || count_after == '0) begin
        beat.out_byte = running_crc[7:0];
        beat.frame_end = 1'b0;
        tx_due.push_back(beat);
        beat.out_byte = running_crc[15:8];
        beat.frame_end = 1'b1;
        tx_due.push_back(beat);
        running_crc    = CrcInit;
        bytes_in_frame = '0;
      end else begin
        bytes_in_frame = count_after;
      end
    endfunction

    // Compares one accepted transmit byte with the oldest one still due.
    function void match_tx(logic [ByteW-1:0] got_byte, logic got_end);
      tx_beat_t want;
      if (tx_due.size() == 0) begin
        mismatch_count++;
        $display("%0t: stray tx transaction: expected none, actual %02h/%0b",
                 $time, got_byte, got_end);
        return;
      end
      want = tx_due.pop_front();
      if (got_byte !== want.out_byte) begin
        mismatch_count++;
        $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                 $time, want.out_byte, got_byte);
      end
      if (got_end !== want.frame_end) begin
        mismatch_count++;
        $display("%0t: frame_end mismatch: expected %0b, actual %0b",
                 $time, want.frame_end, got_end);
      end
    endfunction

    function int unsigned bytes_pending();
      return tx_due.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  crc16fa_in_if  payload_ch ();
  crc16fa_out_if tx_ch ();

  crc16_frame_appender #(
    .PAYLOAD_BYTES(FrameBytes)
  ) DUT (
    .clk    (clk),
    .rst    (rst),
    .payload(payload_ch),
    .tx     (tx_ch)
  );

  crc_tail_tracker board;

  // Idling controls, changed by the main sequence between phases.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_request = 1'b0;
  int unsigned quiet_cycles = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  // Receiver: a fresh ready decision every cycle. When a hold-off is requested,
  // ready stays low for the hold-off length counted here, whatever the sender does.
  initial begin
    tx_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        tx_ch.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_request = 1'b0;
      end
      tx_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: both channels are sampled at the same edge, input first, so a
  // payload byte is always noted before any tx transaction it can cause.
  // Signals read right after the edge still hold their pre-edge values since
  // every driver here and in the block updates through nonblocking assignments.
  always @(posedge clk) begin
    if (!rst) begin
      if ((payload_ch.valid && payload_ch.ready) || (tx_ch.valid && tx_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (payload_ch.valid && payload_ch.ready) begin
        board.take_payload(payload_ch.data_byte);
      end
      if (tx_ch.valid && tx_ch.ready) begin
        board.match_tx(tx_ch.out_byte, tx_ch.frame_end);
      end
      if (quiet_cycles >= QuietLimit) begin
        $display("%0t: no transaction for %0d cycles", $time, QuietLimit);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Offers one payload byte and returns at the edge where it was taken. A gap,
  // when one is drawn, lowers valid first; valid is never lowered and raised
  // again within one time step.
  task automatic send_payload(input logic [ByteW-1:0] value);
    if ($urandom_range(99) < send_idle_pct) begin
      payload_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    payload_ch.valid     <= 1'b1;
    payload_ch.data_byte <= value;
    @(posedge clk);
    while (!payload_ch.ready) @(posedge clk);
  endtask

  // Waits until every predicted tx byte has been seen; valid is dropped first.
  task automatic wait_drained();
    payload_ch.valid <= 1'b0;
    while (board.bytes_pending() != 0) @(posedge clk);
  endtask

  task automatic random_phase(input int unsigned count, input int unsigned send_pct,
                              input int unsigned stall_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_payload(ByteW'($urandom_range(255, 0)));
    wait_drained();
  endtask

  initial begin
    logic [ByteW-1:0] opening_frame [FrameBytes];
    int               idx;
    board = new();
    rst <= 1'b1;
    payload_ch.valid     <= 1'b0;
    payload_ch.data_byte <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed part, with no idling: a frame with the byte extremes and
    // alternating bit patterns, then a frame of all ones and one of all zeros.
    // Each checks the CRC over the whole frame and that the CRC state starts
    // over after the frame closes.
    opening_frame = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h55, 8'hAA, 8'h7F, 8'hFE};
    for (idx = 0; idx < FrameBytes; idx++) send_payload(opening_frame[idx]);
    repeat (FrameBytes) send_payload(8'hFF);
    repeat (FrameBytes) send_payload(8'h00);
    wait_drained();

    // Random bytes under the different idling patterns. Frames run on across
    // phase boundaries, so the CRC tail falls at different points in different phases.
    random_phase(44, 0, 0);
    random_phase(44, 86, 0);
    random_phase(44, 0, 86);
    random_phase(44, 26, 26);

    // Back pressure: the receiver holds off for a long stretch while the
    // sender keeps offering, so the block fills up and drops payload ready.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = 1'b1;
    repeat (30) send_payload(ByteW'($urandom_range(255, 0)));
    wait_drained();

    // Keep watching for a while to catch any byte the block sends on its own.
    repeat (TailCycles) @(posedge clk);
    if (board.mismatch_count == 0 && board.bytes_pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
